### design/btip_pkg.sv
// Shared types and constants for the BER tag identifier parser.
// Used by every module of the block; depends on nothing.
`default_nettype none

package btip_pkg;

  localparam int unsigned TagNumW   = 32;
  localparam int unsigned GroupBits = 7;
  localparam int unsigned CountW    = 3;

  // Largest number of base-128 groups that a long-form tag may carry.
  localparam logic [CountW-1:0] MaxGroups = 3'd5;

  // Low five bits of a first octet that mark the long form.
  localparam logic [4:0] LongFormMark = 5'h1F;

  typedef enum logic [1:0] {
    StOk        = 2'd0,
    StInvalid   = 2'd1,
    StTruncated = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       source_empty;
  } in_word_t;

  typedef struct packed {
    status_e              status;
    logic [1:0]           tag_class;
    logic                 constructed;
    logic [TagNumW-1:0]   tag_number;
  } out_word_t;

endpackage

`default_nettype wire

### design/btip_step.sv
// Parser state and the decode of one identifier octet.
// Depends on btip_pkg for the word types, status codes and limits.
`default_nettype none

module btip_step (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              go_i,
  input  wire btip_pkg::in_word_t word_i,
  output logic                   res_vld_o,
  output btip_pkg::out_word_t    res_o
);

  logic                               lf_q, lf_d;
  logic [1:0]                         cls_q, cls_d;
  logic                               pc_q, pc_d;
  logic [btip_pkg::TagNumW-1:0]       acc_q, acc_d;
  logic [btip_pkg::CountW-1:0]        cnt_q, cnt_d;
  logic [btip_pkg::TagNumW-1:0]       acc_next;
  logic [7:0]                         b;

  assign b        = word_i.in_byte;
  assign acc_next = {acc_q[btip_pkg::TagNumW-btip_pkg::GroupBits-1:0],
                     b[btip_pkg::GroupBits-1:0]};

  always_comb begin
    lf_d      = lf_q;
    cls_d     = cls_q;
    pc_d      = pc_q;
    acc_d     = acc_q;
    cnt_d     = cnt_q;
    res_vld_o = 1'b0;
    res_o     = '{status: btip_pkg::StOk, tag_class: cls_q, constructed: pc_q,
                  tag_number: '0};
    if (!lf_q) begin
      // An empty source while idle is simply skipped.
      if (!word_i.source_empty) begin
        cls_d             = b[7:6];
        pc_d              = b[5];
        res_o.tag_class   = b[7:6];
        res_o.constructed = b[5];
        if (b[4:0] != btip_pkg::LongFormMark) begin
          res_vld_o        = 1'b1;
          res_o.tag_number = {{(btip_pkg::TagNumW-5){1'b0}}, b[4:0]};
        end else begin
          lf_d  = 1'b1;
          acc_d = '0;
          cnt_d = '0;
        end
      end
    end else if (word_i.source_empty) begin
      res_vld_o    = 1'b1;
      res_o.status = btip_pkg::StTruncated;
      lf_d         = 1'b0;
      acc_d        = '0;
      cnt_d        = '0;
    end else if (cnt_q >= btip_pkg::MaxGroups) begin
      res_vld_o    = 1'b1;
      res_o.status = btip_pkg::StInvalid;
      lf_d         = 1'b0;
      acc_d        = '0;
      cnt_d        = '0;
    end else begin
      cnt_d = cnt_q + 1'b1;
      if (!b[7]) begin
        res_vld_o        = 1'b1;
        res_o.tag_number = acc_next;
        lf_d             = 1'b0;
        acc_d            = '0;
        cnt_d            = '0;
      end else begin
        acc_d = acc_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lf_q  <= 1'b0;
      cls_q <= '0;
      pc_q  <= 1'b0;
      acc_q <= '0;
      cnt_q <= '0;
    end else if (go_i) begin
      lf_q  <= lf_d;
      cls_q <= cls_d;
      pc_q  <= pc_d;
      acc_q <= acc_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

### design/btip_out_reg.sv
// Result register of the parser, drives the output channel.
// Depends on btip_pkg for the result word type.
`default_nettype none

module btip_out_reg (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               load_i,
  input  wire btip_pkg::out_word_t word_i,
  output logic                    ready_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output btip_pkg::out_word_t     out_data_o
);

  logic                vld_q, vld_d;
  btip_pkg::out_word_t data_q;

  // The register can take a new word when it is empty or its word leaves now.
  assign ready_o = !vld_q || !out_stall_i;

  always_comb begin
    vld_d = vld_q;
    if (ready_o) begin
      vld_d = load_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && load_i) begin
      data_q <= word_i;
    end
  end

  assign out_valid_o = vld_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

### design/ber_tag_identifier_parser_unit.sv
// Top level of the BER tag identifier parser: input register, decode, result.
// Depends on btip_pkg, btip_step and btip_out_reg.
`default_nettype none

// Decodes ASN.1 BER identifier octets at one word per cycle while the input
// is not stalled. A word is captured in an input register and decoded by
// the parser state logic once the output register can take a result. Where
// it completes a tag (short form, last long-form group, too many groups or
// an empty source mid-tag), its result is written to the output register at
// the end of that same cycle. Words that only extend a long-form tag, and
// empty words while idle, give no result. The input stalls only while the
// input register is full and the output register holds a result that is
// stalled.

module ber_tag_identifier_parser_unit (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire btip_pkg::in_word_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output btip_pkg::out_word_t      out_data_o
);

  logic                in_vld_q, in_vld_d;
  btip_pkg::in_word_t  in_q;
  logic                out_ready;
  logic                go;
  logic                in_take;
  logic                res_vld;
  btip_pkg::out_word_t res;

  assign go         = in_vld_q && out_ready;
  assign in_stall_o = in_vld_q && !out_ready;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_take) begin
      in_vld_d = 1'b1;
    end else if (go) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
  end

  btip_step u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .go_i      (go),
    .word_i    (in_q),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  btip_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (go && res_vld),
    .word_i      (res),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

### design/btip_checker.sv
// Port-level assertions for the BER tag identifier parser and their bind.
// Depends on btip_pkg and on the ports of ber_tag_identifier_parser_unit.
`default_nettype none

module btip_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_stall_o,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire btip_pkg::out_word_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("output word changed while stalled");

  // The input only backs up when a finished result cannot leave.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // Error results never carry a tag number.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != btip_pkg::StOk) |->
      out_data_o.tag_number == '0)
    else $error("error result with nonzero tag number");

endmodule

bind ber_tag_identifier_parser_unit btip_checker u_btip_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 1ps
// Testbench for ber_tag_identifier_parser_unit: sends BER identifier octets, predicts each
// decoded tag and checks every result word in order. Depends only on btip_pkg and the RTL.

module tb;

  localparam int unsigned QuietLimit    = 1000;
  localparam int unsigned ItemsPerPhase = 617;
  localparam int unsigned ReportLimit   = 10;

  // Tracks the decoder state for every accepted octet and holds the tags still owed.
  class tag_checker;
    bit                           long_form;
    logic [1:0]                   cls_q;
    logic                         pc_q;
    logic [btip_pkg::TagNumW-1:0] accum;
    logic [btip_pkg::CountW-1:0]  groups;
    btip_pkg::out_word_t          awaited_tags[$];
    int unsigned                  failures;

    function void absorb_octet(btip_pkg::in_word_t w);
      btip_pkg::out_word_t t;
      bit                  done;
      t = '0;
      done = 1'b0;
      if (!long_form) begin
        // An empty source between tags leaves everything as it was.
        if (w.source_empty) return;
        cls_q = w.in_byte[7:6];
        pc_q  = w.in_byte[5];
        if (w.in_byte[4:0] != btip_pkg::LongFormMark) begin
          t.status     = btip_pkg::StOk;
          t.tag_number = btip_pkg::TagNumW'(w.in_byte[4:0]);
          done         = 1'b1;
        end else begin
          long_form = 1'b1;
          accum     = '0;
          groups    = '0;
        end
      end else if (w.source_empty) begin
        t.status  = btip_pkg::StTruncated;
        done      = 1'b1;
        long_form = 1'b0;
      end else if (groups >= btip_pkg::MaxGroups) begin
        t.status  = btip_pkg::StInvalid;
        done      = 1'b1;
        long_form = 1'b0;
      end else begin
        groups = groups + 1'b1;
        // The number wraps: only the low 32 bits of the shifted groups survive.
        accum = {accum[btip_pkg::TagNumW-btip_pkg::GroupBits-1:0],
                 w.in_byte[btip_pkg::GroupBits-1:0]};
        if (!w.in_byte[7]) begin
          t.status     = btip_pkg::StOk;
          t.tag_number = accum;
          done         = 1'b1;
          long_form    = 1'b0;
        end
      end
      if (done) begin
        t.tag_class   = cls_q;
        t.constructed = pc_q;
        awaited_tags.push_back(t);
      end
    endfunction

    function void match_tag(btip_pkg::out_word_t got);
      btip_pkg::out_word_t want;
      if (awaited_tags.size() == 0) begin
        failures++;
        if (failures <= ReportLimit)
          $display("unexpected tag word: status=%0d class=%0d constructed=%0d number=%h",
                   got.status, got.tag_class, got.constructed, got.tag_number);
        return;
      end
      want = awaited_tags.pop_front();
      if (got.status !== want.status || got.tag_class !== want.tag_class ||
          got.constructed !== want.constructed || got.tag_number !== want.tag_number) begin
        failures++;
        if (failures <= ReportLimit)
          $display("tag mismatch: expected status=%0d class=%0d constructed=%0d number=%h, %s",
                   want.status, want.tag_class, want.constructed, want.tag_number,
                   $sformatf("got status=%0d class=%0d constructed=%0d number=%h",
                             got.status, got.tag_class, got.constructed, got.tag_number));
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  btip_pkg::in_word_t  in_data_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  btip_pkg::out_word_t out_data_o;

  int unsigned send_idle_pct = 7;
  int unsigned recv_stall_pct = 72;
  int unsigned quiet_cycles = 0;

  tag_checker tracker = new();

  ber_tag_identifier_parser_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Both handshakes are sampled with the values that stood before the edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) tracker.absorb_octet(in_data_i);
      if (out_valid_o && !out_stall_i) tracker.match_tag(out_data_o);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QuietLimit) begin
        $display("tb failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic btip_pkg::in_word_t octet(logic [7:0] b, logic empty);
    btip_pkg::in_word_t w;
    w.in_byte      = b;
    w.source_empty = empty;
    return w;
  endfunction

  // Presents one word after a random idle stretch and returns at the edge that takes it.
  task automatic send_word(input btip_pkg::in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Sends one tag or a lone empty word: mostly well-formed short or long forms, some cut
  // short by an empty source, some with too many groups, and a few noisy continuation octets.
  task automatic send_random_tag(output int unsigned n_sent);
    btip_pkg::in_word_t w;
    int unsigned        pick;
    int unsigned        n_groups;
    int unsigned        cut;
    logic [7:0]         first;
    n_sent = 0;
    pick = $urandom_range(99);
    if (pick < 8) begin
      send_word(octet(8'($urandom), 1'b1));
      n_sent = 1;
      return;
    end
    first = 8'($urandom);
    if (pick < 40) begin
      if (first[4:0] == btip_pkg::LongFormMark) first[4:0] = 5'($urandom_range(30));
      send_word(octet(first, 1'b0));
      n_sent = 1;
      return;
    end
    first[4:0] = btip_pkg::LongFormMark;
    send_word(octet(first, 1'b0));
    n_sent = 1;
    n_groups = (pick < 88) ? $urandom_range(1, int'(btip_pkg::MaxGroups))
                           : int'(btip_pkg::MaxGroups) + 1;
    cut = (pick >= 80 && pick < 88) ? $urandom_range(1, n_groups) : n_groups + 1;
    for (int g = 1; g <= n_groups; g++) begin
      if (g == cut) begin
        send_word(octet(8'($urandom), 1'b1));
        n_sent++;
        return;
      end
      w = octet(8'($urandom), 1'b0);
      if (g <= int'(btip_pkg::MaxGroups) && $urandom_range(19) != 0)
        w.in_byte[7] = (g != n_groups);
      send_word(w);
      n_sent++;
    end
  endtask

  initial begin
    int unsigned n;
    int unsigned total;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Short forms at the extremes of class, flag and number.
    send_word(octet(8'h00, 1'b0));
    send_word(octet(8'hFE, 1'b0));
    send_word(octet(8'h5E, 1'b0));
    // An empty source while waiting for a first octet gives nothing.
    send_word(octet(8'hFF, 1'b1));
    // Long form with a single group.
    send_word(octet(8'h1F, 1'b0));
    send_word(octet(8'h7F, 1'b0));
    // A leading zero group is accepted.
    send_word(octet(8'h3F, 1'b0));
    send_word(octet(8'h80, 1'b0));
    send_word(octet(8'h01, 1'b0));
    // Five full groups, the number wraps past 32 bits.
    send_word(octet(8'hDF, 1'b0));
    repeat (4) send_word(octet(8'hFF, 1'b0));
    send_word(octet(8'h7F, 1'b0));
    // A sixth group makes the tag invalid.
    send_word(octet(8'h7F, 1'b0));
    repeat (5) send_word(octet(8'h80, 1'b0));
    send_word(octet(8'h00, 1'b0));
    // The source runs dry in the middle of a long-form tag.
    send_word(octet(8'h9F, 1'b0));
    send_word(octet(8'h85, 1'b0));
    send_word(octet(8'h00, 1'b1));

    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin
        send_idle_pct  = 72;
        recv_stall_pct = 7;
      end else if (ph == 2) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      total = 0;
      while (total < ItemsPerPhase) begin
        send_random_tag(n);
        total += n;
      end
    end
    in_valid_i <= 1'b0;

    while (tracker.awaited_tags.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (tracker.failures == 0 && tracker.awaited_tags.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

### filelist.f
design/btip_pkg.sv
design/btip_step.sv
design/btip_out_reg.sv
design/ber_tag_identifier_parser_unit.sv
design/btip_checker.sv
tb/sv/tb.sv
